### hw/rtl/pdcs_pkg.sv
// Shared types, constants and slot tables for the PD contract selector.
package pdcs_pkg;

  localparam int SLOT_COUNT = 6;
  localparam int PREF_COUNT = 5;
  localparam int CUR_W      = 13;
  localparam int PW_W       = 18;
  localparam int SEL_W      = 3;
  localparam int SLOT_W     = 3;
  localparam int MV_W       = 15;
  localparam int VOLT_W     = 5;
  localparam int EN_W       = 17;
  localparam int BAND_W     = 8;
  localparam int PROD_W     = PW_W + BAND_W;
  localparam int THR_W      = PW_W + 1 + BAND_W;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [EN_W-1:0]   ENOUGH_RST = EN_W'(45000);
  localparam logic [CUR_W-1:0]  CAP_RST    = CUR_W'(5000);
  localparam logic [MV_W-1:0]   FLOOR_RST  = MV_W'(9000);
  localparam logic [MV_W-1:0]   VCAP_RST   = MV_W'(20000);
  localparam logic [BAND_W-1:0] NUM_RST    = BAND_W'(9);
  localparam logic [BAND_W-1:0] DEN_RST    = BAND_W'(10);

  localparam logic [SEL_W-1:0] SEL_NONE = '0;

  typedef enum logic [2:0] {
    REG_ENOUGH = 3'd0,
    REG_CAP    = 3'd1,
    REG_FLOOR  = 3'd2,
    REG_VCAP   = 3'd3,
    REG_NUM    = 3'd4,
    REG_DEN    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [EN_W-1:0]   enough;
    logic [CUR_W-1:0]  cap;
    logic [MV_W-1:0]   floor_mv;
    logic [MV_W-1:0]   vcap_mv;
    logic [BAND_W-1:0] num;
    logic [BAND_W-1:0] den;
  } cfg_t;

  typedef struct packed {
    logic                             a_hit;
    logic [SEL_W-1:0]                 a_sel;
    logic [SEL_W-1:0]                 c_sel;
    logic [PW_W-1:0]                  best;
    logic [SLOT_COUNT-1:0]            cand;
    logic [SLOT_COUNT-1:0][PW_W-1:0]  pw;
  } class_t;

  typedef struct packed {
    logic [SEL_W-1:0] sel;
    logic [MV_W-1:0]  mv;
  } result_t;

  function automatic logic [VOLT_W-1:0] slot_volts(input logic [SLOT_W-1:0] s);
    case (s)
      3'd0:    slot_volts = VOLT_W'(5);
      3'd1:    slot_volts = VOLT_W'(9);
      3'd2:    slot_volts = VOLT_W'(12);
      3'd3:    slot_volts = VOLT_W'(15);
      3'd4:    slot_volts = VOLT_W'(18);
      3'd5:    slot_volts = VOLT_W'(20);
      default: slot_volts = '0;
    endcase
  endfunction

  function automatic logic [MV_W-1:0] slot_mv(input logic [SLOT_W-1:0] s);
    case (s)
      3'd0:    slot_mv = MV_W'(5000);
      3'd1:    slot_mv = MV_W'(9000);
      3'd2:    slot_mv = MV_W'(12000);
      3'd3:    slot_mv = MV_W'(15000);
      3'd4:    slot_mv = MV_W'(18000);
      3'd5:    slot_mv = MV_W'(20000);
      default: slot_mv = '0;
    endcase
  endfunction

  // preference order 15, 12, 18, 20, 9 V
  function automatic logic [SLOT_W-1:0] pref_slot(input logic [2:0] p);
    case (p)
      3'd0:    pref_slot = SLOT_W'(3);
      3'd1:    pref_slot = SLOT_W'(2);
      3'd2:    pref_slot = SLOT_W'(4);
      3'd3:    pref_slot = SLOT_W'(5);
      3'd4:    pref_slot = SLOT_W'(1);
      default: pref_slot = SLOT_W'(1);
    endcase
  endfunction

endpackage

### hw/rtl/pd_contract_selector.sv
// Top level of the PD contract selector: register port, front, queue and back.
// Takes one source capability request per cycle while full is low and returns
// one result per request, in order. A request passes through the
// clamp-and-power register of the front, one entry of the two-deep middle
// queue, the band multiply register of the back and an entry of the two-deep
// result queue before its result is visible. Sustained rate is one request per
// cycle while results are popped as they appear. Registers sit at byte address
// 4*i, i = 0..5 in the order enough power, current cap, voltage floor, voltage
// cap, band numerator, band denominator; a zero denominator acts as one. Write
// registers only while no request is in flight.
module pd_contract_selector (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pdcs_pkg::ADDR_W-1:0]        paddr,
  input  logic [pdcs_pkg::DATA_W-1:0]        pwdata,
  output logic [pdcs_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  input  logic                               push,
  output logic                               full,
  input  logic [pdcs_pkg::SLOT_COUNT-1:0]    detected_slots,
  input  logic [pdcs_pkg::CUR_W-1:0]         current_5v_ma,
  input  logic [pdcs_pkg::CUR_W-1:0]         current_9v_ma,
  input  logic [pdcs_pkg::CUR_W-1:0]         current_12v_ma,
  input  logic [pdcs_pkg::CUR_W-1:0]         current_15v_ma,
  input  logic [pdcs_pkg::CUR_W-1:0]         current_18v_ma,
  input  logic [pdcs_pkg::CUR_W-1:0]         current_20v_ma,
  output logic                               empty,
  input  logic                               pop,
  output logic [pdcs_pkg::SEL_W-1:0]         selected_slot,
  output logic [pdcs_pkg::MV_W-1:0]          selected_mv
);

  pdcs_pkg::cfg_t     cfg;
  pdcs_pkg::reg_idx_t reg_idx;
  pdcs_pkg::class_t   fq_data;
  pdcs_pkg::class_t   qb_data;
  logic [pdcs_pkg::SLOT_COUNT-1:0][pdcs_pkg::CUR_W-1:0] cur;
  logic               wr_en;
  logic               fq_push;
  logic               fq_full;
  logic               qb_pop;
  logic               qb_empty;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = pdcs_pkg::reg_idx_t'(paddr[pdcs_pkg::ADDR_W-1:2]);

  assign cur[0] = current_5v_ma;
  assign cur[1] = current_9v_ma;
  assign cur[2] = current_12v_ma;
  assign cur[3] = current_15v_ma;
  assign cur[4] = current_18v_ma;
  assign cur[5] = current_20v_ma;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enough   <= pdcs_pkg::ENOUGH_RST;
      cfg.cap      <= pdcs_pkg::CAP_RST;
      cfg.floor_mv <= pdcs_pkg::FLOOR_RST;
      cfg.vcap_mv  <= pdcs_pkg::VCAP_RST;
      cfg.num      <= pdcs_pkg::NUM_RST;
      cfg.den      <= pdcs_pkg::DEN_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        pdcs_pkg::REG_ENOUGH: cfg.enough   <= pwdata[pdcs_pkg::EN_W-1:0];
        pdcs_pkg::REG_CAP:    cfg.cap      <= pwdata[pdcs_pkg::CUR_W-1:0];
        pdcs_pkg::REG_FLOOR:  cfg.floor_mv <= pwdata[pdcs_pkg::MV_W-1:0];
        pdcs_pkg::REG_VCAP:   cfg.vcap_mv  <= pwdata[pdcs_pkg::MV_W-1:0];
        pdcs_pkg::REG_NUM:    cfg.num      <= pwdata[pdcs_pkg::BAND_W-1:0];
        pdcs_pkg::REG_DEN:    cfg.den      <= pwdata[pdcs_pkg::BAND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pdcs_pkg::REG_ENOUGH: prdata = pdcs_pkg::DATA_W'(cfg.enough);
      pdcs_pkg::REG_CAP:    prdata = pdcs_pkg::DATA_W'(cfg.cap);
      pdcs_pkg::REG_FLOOR:  prdata = pdcs_pkg::DATA_W'(cfg.floor_mv);
      pdcs_pkg::REG_VCAP:   prdata = pdcs_pkg::DATA_W'(cfg.vcap_mv);
      pdcs_pkg::REG_NUM:    prdata = pdcs_pkg::DATA_W'(cfg.num);
      pdcs_pkg::REG_DEN:    prdata = pdcs_pkg::DATA_W'(cfg.den);
      default:              prdata = '0;
    endcase
  end

  pdcs_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .push           (push),
    .full           (full),
    .detected_slots (detected_slots),
    .cur            (cur),
    .q_push         (fq_push),
    .q_full         (fq_full),
    .q_data         (fq_data)
  );

  pdcs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fq_push),
    .push_data (fq_data),
    .full      (fq_full),
    .pop       (qb_pop),
    .empty     (qb_empty),
    .pop_data  (qb_data)
  );

  pdcs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_empty       (qb_empty),
    .q_data        (qb_data),
    .q_pop         (qb_pop),
    .pop           (pop),
    .empty         (empty),
    .selected_slot (selected_slot),
    .selected_mv   (selected_mv)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (selected_slot <= pdcs_pkg::SEL_W'(pdcs_pkg::SLOT_COUNT)))
    else $error("selected slot out of range");

  a_mv_match: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((selected_slot == pdcs_pkg::SEL_NONE) == (selected_mv == '0)))
    else $error("voltage does not match slot");

  a_no_pop_on_empty: assert property (@(posedge clk) disable iff (rst)
    qb_pop |-> !qb_empty)
    else $error("back part took from an empty queue");

endmodule

### hw/rtl/pdcs_front.sv
// Front part: accepts requests, clamps currents, forms slot powers and classifies.
module pdcs_front (
  input  logic                                     clk,
  input  logic                                     rst,
  input  pdcs_pkg::cfg_t                           cfg,
  input  logic                                     push,
  output logic                                     full,
  input  logic [pdcs_pkg::SLOT_COUNT-1:0]          detected_slots,
  input  logic [pdcs_pkg::SLOT_COUNT-1:0][pdcs_pkg::CUR_W-1:0] cur,
  output logic                                     q_push,
  input  logic                                     q_full,
  output pdcs_pkg::class_t                         q_data
);

  logic                                              f1_valid;
  logic [pdcs_pkg::SLOT_COUNT-1:0]                   mask;
  logic [pdcs_pkg::SLOT_COUNT-1:0]                   nz;
  logic [pdcs_pkg::SLOT_COUNT-1:0][pdcs_pkg::PW_W-1:0] pw;
  logic [pdcs_pkg::SLOT_COUNT-1:0][pdcs_pkg::PW_W-1:0] pw_in;
  logic [pdcs_pkg::SLOT_COUNT-1:0]                   nz_in;
  logic                                              f1_take;

  assign f1_take = !f1_valid || !q_full;
  assign full    = !f1_take;
  assign q_push  = f1_valid && !q_full;

  always_comb begin
    logic [pdcs_pkg::CUR_W-1:0] cur_c;
    cur_c = '0;
    for (int s = 0; s < pdcs_pkg::SLOT_COUNT; s++) begin
      cur_c = (cur[s] > cfg.cap) ? cfg.cap : cur[s];
      pw_in[s] = pdcs_pkg::PW_W'(cur_c) *
                 pdcs_pkg::PW_W'(pdcs_pkg::slot_volts(pdcs_pkg::SLOT_W'(s)));
      nz_in[s] = detected_slots[s] && (cur[s] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (f1_take) begin
      f1_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && f1_take) begin
      mask <= detected_slots;
      nz   <= nz_in;
      pw   <= pw_in;
    end
  end

  always_comb begin
    logic [pdcs_pkg::SLOT_W-1:0] ps;
    logic [pdcs_pkg::SLOT_COUNT-1:0] inr;
    logic [pdcs_pkg::MV_W-1:0] mv;
    ps = '0;
    inr = '0;
    mv = '0;
    q_data = '0;
    q_data.pw = pw;
    for (int s = 0; s < pdcs_pkg::SLOT_COUNT; s++) begin
      mv = pdcs_pkg::slot_mv(pdcs_pkg::SLOT_W'(s));
      inr[s] = (mv >= cfg.floor_mv) && (mv <= cfg.vcap_mv);
    end
    q_data.cand = mask & inr;
    // walk preference backwards so the first preferred hit wins
    for (int p = pdcs_pkg::PREF_COUNT - 1; p >= 0; p--) begin
      ps = pdcs_pkg::pref_slot(3'(p));
      if (mask[ps] && (pw[ps] >= pdcs_pkg::PW_W'(cfg.enough))) begin
        q_data.a_hit = 1'b1;
        q_data.a_sel = pdcs_pkg::SEL_W'(ps) + pdcs_pkg::SEL_W'(1);
      end
    end
    for (int s = 0; s < pdcs_pkg::SLOT_COUNT; s++) begin
      if (q_data.cand[s] && (pw[s] > q_data.best)) begin
        q_data.best = pw[s];
      end
      if (nz[s]) begin
        q_data.c_sel = pdcs_pkg::SEL_W'(s + 1);
      end
    end
  end

endmodule

### hw/rtl/pdcs_queue.sv
// Two-entry queue between the front and back parts.
module pdcs_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pdcs_pkg::class_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output pdcs_pkg::class_t pop_data
);

  pdcs_pkg::class_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

### hw/rtl/pdcs_back.sv
// Back part: band multiply, final pick and the result queue.
module pdcs_back (
  input  logic                          clk,
  input  logic                          rst,
  input  pdcs_pkg::cfg_t                cfg,
  input  logic                          q_empty,
  input  pdcs_pkg::class_t              q_data,
  output logic                          q_pop,
  input  logic                          pop,
  output logic                          empty,
  output logic [pdcs_pkg::SEL_W-1:0]    selected_slot,
  output logic [pdcs_pkg::MV_W-1:0]     selected_mv
);

  logic                                   b1_valid;
  logic                                   a_hit;
  logic [pdcs_pkg::SEL_W-1:0]             a_sel;
  logic [pdcs_pkg::SEL_W-1:0]             c_sel;
  logic                                   best_nz;
  logic [pdcs_pkg::PREF_COUNT-1:0]        cand_p;
  logic [pdcs_pkg::PROD_W-1:0]            prod;
  logic [pdcs_pkg::PREF_COUNT-1:0][pdcs_pkg::THR_W-1:0] thr;

  logic [pdcs_pkg::PREF_COUNT-1:0][pdcs_pkg::THR_W-1:0] thr_in;
  logic [pdcs_pkg::PREF_COUNT-1:0]        cand_in;
  logic [pdcs_pkg::BAND_W-1:0]            den_eff;
  logic                                   b1_take;

  pdcs_pkg::result_t res_mem [2];
  pdcs_pkg::result_t res_in;
  logic       res_wr;
  logic       res_rd;
  logic [1:0] res_cnt;
  logic       res_full;
  logic       res_push;
  logic       res_pop;

  assign res_full = (res_cnt == 2'd2);
  assign empty    = (res_cnt == 2'd0);
  assign b1_take  = !b1_valid || !res_full;
  assign q_pop    = !q_empty && b1_take;
  assign res_push = b1_valid && !res_full;
  assign res_pop  = pop && !empty;
  assign den_eff  = (cfg.den == '0) ? pdcs_pkg::BAND_W'(1) : cfg.den;

  // band test: pw >= floor(best*num/den) is best*num < (pw+1)*den
  always_comb begin
    logic [pdcs_pkg::SLOT_W-1:0] ps;
    ps = '0;
    for (int p = 0; p < pdcs_pkg::PREF_COUNT; p++) begin
      ps = pdcs_pkg::pref_slot(3'(p));
      thr_in[p]  = (pdcs_pkg::THR_W'(q_data.pw[ps]) + pdcs_pkg::THR_W'(1)) *
                   pdcs_pkg::THR_W'(den_eff);
      cand_in[p] = q_data.cand[ps];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (b1_take) begin
      b1_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_hit   <= q_data.a_hit;
      a_sel   <= q_data.a_sel;
      c_sel   <= q_data.c_sel;
      best_nz <= (q_data.best != '0);
      cand_p  <= cand_in;
      prod    <= pdcs_pkg::PROD_W'(q_data.best) * pdcs_pkg::PROD_W'(cfg.num);
      thr     <= thr_in;
    end
  end

  always_comb begin
    logic [pdcs_pkg::SEL_W-1:0] sel;
    logic [pdcs_pkg::SLOT_W-1:0] ps;
    sel = c_sel;
    ps = '0;
    if (best_nz) begin
      for (int p = pdcs_pkg::PREF_COUNT - 1; p >= 0; p--) begin
        ps = pdcs_pkg::pref_slot(3'(p));
        if (cand_p[p] && (pdcs_pkg::THR_W'(prod) < thr[p])) begin
          sel = pdcs_pkg::SEL_W'(ps) + pdcs_pkg::SEL_W'(1);
        end
      end
    end
    if (a_hit) begin
      sel = a_sel;
    end
    res_in.sel = sel;
    if (sel == pdcs_pkg::SEL_NONE) begin
      res_in.mv = '0;
    end else begin
      res_in.mv = pdcs_pkg::slot_mv(pdcs_pkg::SLOT_W'(sel - pdcs_pkg::SEL_W'(1)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr  <= 1'b0;
      res_rd  <= 1'b0;
      res_cnt <= 2'd0;
    end else begin
      if (res_push) begin
        res_wr <= !res_wr;
      end
      if (res_pop) begin
        res_rd <= !res_rd;
      end
      if (res_push && !res_pop) begin
        res_cnt <= res_cnt + 2'd1;
      end else if (res_pop && !res_push) begin
        res_cnt <= res_cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem[res_wr] <= res_in;
    end
  end

  assign selected_slot = res_mem[res_rd].sel;
  assign selected_mv   = res_mem[res_rd].mv;

endmodule
